FILE: design/kmrg_pkg.sv
// Shared types, codes and constants of the key match row gather block.
package kmrg_pkg;

    // Default sizing, handed down from the top level.
    localparam int ENTRIES_DEF      = 64;
    localparam int ROW_MAX_DEF      = 64;
    localparam int ELEMENT_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // Fixed field widths of the stream channels.
    localparam int KEY_W      = 32;
    localparam int POS_W      = 6;
    localparam int DATA_W     = 32;
    localparam int LEN_W      = 7;
    localparam int FILL_W     = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 40;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_COUNT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_LENGTH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FILL_VALUE = 2'd2;

    // Request kinds on the input tuser.
    typedef enum logic [1:0] {
        OP_LOAD_KEY = 2'd0,
        OP_LOAD_ROW = 2'd1,
        OP_LOOKUP   = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } back_state_t;

    // Classified request passed from front to back.
    typedef struct packed {
        op_t                kind;
        logic [KEY_W-1:0]   key;
        logic [POS_W-1:0]   entry;
        logic [POS_W-1:0]   elem;
        logic [DATA_W-1:0]  data;
    } kmrg_cmd_t;

endpackage

FILE: design/kmrg_front.sv
// Front end: takes input requests, drops ignored ones and holds one for the queue.
module kmrg_front #(
    parameter int ENTRIES = kmrg_pkg::ENTRIES_DEF,
    parameter int ROW_MAX = kmrg_pkg::ROW_MAX_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] search_key, [37:32] entry_position, [43:38] element_position,
    // [75:44] element_data, [79:76] zero
    input  logic [kmrg_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]                     s_tuser,
    input  logic                           q_full,
    output logic                           q_push,
    output kmrg_pkg::kmrg_cmd_t            q_cmd
);
    import kmrg_pkg::*;

    logic      hold_valid_reg, hold_valid_next;
    kmrg_cmd_t hold_cmd_reg;
    kmrg_cmd_t in_cmd;
    logic      keep;
    logic      accept;

    // Unpack the request fields
    always_comb begin
        in_cmd.kind  = op_t'(s_tuser);
        in_cmd.key   = s_tdata[31:0];
        in_cmd.entry = s_tdata[37:32];
        in_cmd.elem  = s_tdata[43:38];
        in_cmd.data  = s_tdata[75:44];
    end

    // Classify: drop out-of-range loads and the reserved kind
    always_comb begin
        unique case (in_cmd.kind)
            OP_LOAD_KEY: keep = (int'(in_cmd.entry) < ENTRIES);
            OP_LOAD_ROW: keep = (int'(in_cmd.entry) < ENTRIES) &&
                                (int'(in_cmd.elem) < ROW_MAX);
            OP_LOOKUP:   keep = 1'b1;
            default:     keep = 1'b0;
        endcase
    end

    assign q_push   = hold_valid_reg && !q_full;
    assign s_tready = !hold_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_cmd    = hold_cmd_reg;

    // Advance the holding stage
    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (accept) begin
            hold_valid_next = keep;
        end else if (q_push) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_cmd_reg <= in_cmd;
        end
    end

endmodule

FILE: design/kmrg_queue.sv
// Short request queue between the front end and the back end.
module kmrg_queue #(
    parameter int DEPTH = kmrg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  kmrg_pkg::kmrg_cmd_t din,
    output logic                full,
    input  logic                pop,
    output kmrg_pkg::kmrg_cmd_t dout,
    output logic                valid
);
    import kmrg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kmrg_cmd_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign dout    = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap and track fill
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (int'(wr_ptr_reg) == DEPTH - 1) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = (int'(rd_ptr_reg) == DEPTH - 1) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: design/kmrg_back.sv
// Back end: key and row stores, descending key scan and row streaming.
module kmrg_back #(
    parameter int ENTRIES      = kmrg_pkg::ENTRIES_DEF,
    parameter int ROW_MAX      = kmrg_pkg::ROW_MAX_DEF,
    parameter int ELEMENT_BITS = kmrg_pkg::ELEMENT_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  kmrg_pkg::kmrg_cmd_t         q_cmd,
    output logic                        q_pop,
    input  logic [kmrg_pkg::LEN_W-1:0]  key_count,
    input  logic [kmrg_pkg::LEN_W-1:0]  row_length,
    input  logic [kmrg_pkg::FILL_W-1:0] fill_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_hit,
    output logic [kmrg_pkg::POS_W-1:0]  out_entry,
    output logic [kmrg_pkg::DATA_W-1:0] out_element,
    output logic                        out_last
);
    import kmrg_pkg::*;

    localparam int ENT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int DEPTH  = ENTRIES * ROW_MAX;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EB     = ELEMENT_BITS;

    // Storage
    logic [KEY_W-1:0] key_mem [ENTRIES];
    logic [EB-1:0]    row_mem [DEPTH];
    logic [KEY_W-1:0] key_rd_data_reg;
    logic [EB-1:0]    row_rd_data_reg;

    // Sequencer
    back_state_t      state_reg, state_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] emit_idx_reg, emit_idx_next;
    logic [CNT_W-1:0] scan_left_reg, scan_left_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [ENT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             hit_reg, hit_next;
    logic [ENT_W-1:0] pos_reg, pos_next;

    // Read data stage and output register
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_last_reg, s1_last_next;
    logic              s1_hit_reg, s1_hit_next;
    logic [POS_W-1:0]  s1_pos_reg, s1_pos_next;
    logic              o_valid_reg, o_valid_next;
    logic              o_hit_reg, o_hit_next;
    logic [POS_W-1:0]  o_pos_reg, o_pos_next;
    logic [DATA_W-1:0] o_data_reg, o_data_next;
    logic              o_last_reg, o_last_next;

    logic              start_lookup;
    logic              key_we, row_we;
    logic [ENT_W-1:0]  key_waddr, key_raddr;
    logic [ADDR_W-1:0] row_waddr, row_raddr;
    logic              scan_issue, scan_match;
    logic              out_free, s1_move, rd_issue, issue_last;
    logic [LEN_W-1:0]  len_sat;
    logic [CNT_W-1:0]  count_sat;
    logic [EB-1:0]     fill_masked;

    // Decode the popped request
    assign q_pop        = (state_reg == ST_IDLE) && q_valid;
    assign start_lookup = q_pop && (q_cmd.kind == OP_LOOKUP);
    assign key_we       = q_pop && (q_cmd.kind == OP_LOAD_KEY);
    assign row_we       = q_pop && (q_cmd.kind == OP_LOAD_ROW);
    assign key_waddr    = ENT_W'(q_cmd.entry);
    assign row_waddr    = ADDR_W'(int'(q_cmd.entry) * ROW_MAX + int'(q_cmd.elem));

    // Saturate the lookup limits
    always_comb begin
        if (row_length == '0) begin
            len_sat = LEN_W'(1);
        end else if (int'(row_length) > ROW_MAX) begin
            len_sat = LEN_W'(ROW_MAX);
        end else begin
            len_sat = row_length;
        end
        if (int'(key_count) > ENTRIES) begin
            count_sat = CNT_W'(ENTRIES);
        end else begin
            count_sat = CNT_W'(key_count);
        end
    end

    // Scan from the highest entry down; the first match is the winner
    assign scan_issue = (scan_left_reg != '0);
    assign key_raddr  = ENT_W'(scan_left_reg - 1'b1);
    assign scan_match = cmp_valid_reg && (key_rd_data_reg == key_reg);

    // Row read handshake between memory stage and output register
    assign out_free    = !o_valid_reg || out_ready;
    assign s1_move     = s1_valid_reg && out_free;
    assign rd_issue    = (state_reg == ST_EMIT) && (!s1_valid_reg || s1_move);
    assign issue_last  = (emit_idx_reg == LEN_W'(len_reg - 1'b1));
    assign row_raddr   = ADDR_W'(int'(pos_reg) * ROW_MAX + int'(emit_idx_reg));
    assign fill_masked = EB'(fill_value);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_lookup) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_match || !scan_issue) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (rd_issue && issue_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer datapath
    always_comb begin
        key_next       = key_reg;
        len_next       = len_reg;
        emit_idx_next  = emit_idx_reg;
        scan_left_next = scan_left_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_lookup) begin
                    key_next       = q_cmd.key;
                    len_next       = len_sat;
                    emit_idx_next  = '0;
                    scan_left_next = count_sat;
                    cmp_valid_next = 1'b0;
                end
            end
            ST_SCAN: begin
                cmp_valid_next = scan_issue;
                cmp_idx_next   = key_raddr;
                if (scan_issue) begin
                    scan_left_next = CNT_W'(scan_left_reg - 1'b1);
                end
                if (scan_match) begin
                    hit_next = 1'b1;
                    pos_next = cmp_idx_reg;
                end else if (!scan_issue) begin
                    hit_next = 1'b0;
                    pos_next = '0;
                end
            end
            ST_EMIT: begin
                if (rd_issue) begin
                    emit_idx_next = LEN_W'(emit_idx_reg + 1'b1);
                end
            end
            default: ;
        endcase
    end

    // Read stage and output register
    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_last_next  = s1_last_reg;
        s1_hit_next   = s1_hit_reg;
        s1_pos_next   = s1_pos_reg;
        o_valid_next  = o_valid_reg;
        o_hit_next    = o_hit_reg;
        o_pos_next    = o_pos_reg;
        o_data_next   = o_data_reg;
        o_last_next   = o_last_reg;
        if (rd_issue) begin
            s1_valid_next = 1'b1;
            s1_last_next  = issue_last;
            s1_hit_next   = hit_reg;
            s1_pos_next   = POS_W'(pos_reg);
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
        if (s1_move) begin
            o_valid_next = 1'b1;
            o_hit_next   = s1_hit_reg;
            o_pos_next   = s1_pos_reg;
            o_data_next  = s1_hit_reg ? DATA_W'(row_rd_data_reg) : DATA_W'(fill_masked);
            o_last_next  = s1_last_reg;
        end else if (out_ready) begin
            o_valid_next = 1'b0;
        end
    end

    assign out_valid   = o_valid_reg;
    assign out_hit     = o_hit_reg;
    assign out_entry   = o_pos_reg;
    assign out_element = o_data_reg;
    assign out_last    = o_last_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_left_reg <= '0;
            cmp_valid_reg <= 1'b0;
            emit_idx_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            o_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            scan_left_reg <= scan_left_next;
            cmp_valid_reg <= cmp_valid_next;
            emit_idx_reg  <= emit_idx_next;
            s1_valid_reg  <= s1_valid_next;
            o_valid_reg   <= o_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        len_reg     <= len_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_reg     <= hit_next;
        pos_reg     <= pos_next;
        s1_last_reg <= s1_last_next;
        s1_hit_reg  <= s1_hit_next;
        s1_pos_reg  <= s1_pos_next;
        o_hit_reg   <= o_hit_next;
        o_pos_reg   <= o_pos_next;
        o_data_reg  <= o_data_next;
        o_last_reg  <= o_last_next;
    end

    // Key store
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr] <= q_cmd.key;
        end
    end

    always_ff @(posedge aclk) begin
        key_rd_data_reg <= key_mem[key_raddr];
    end

    // Row store
    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[row_waddr] <= q_cmd.data[EB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_issue) begin
            row_rd_data_reg <= row_mem[row_raddr];
        end
    end

    // No row read past the row length
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_issue |-> (emit_idx_reg < len_reg))
        else $error("row read beyond row length");

    // Row length stays within its clamp while streaming
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (len_reg != '0) && (int'(len_reg) <= ROW_MAX))
        else $error("row length out of range during emit");

    // Issuing the final element returns the sequencer to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_issue && issue_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after last element");

    // A miss reports entry zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (o_valid_reg && !o_hit_reg) |-> (o_pos_reg == '0))
        else $error("miss with nonzero entry");

endmodule

FILE: design/key_match_row_gather.sv
// Top level of the key match row gather block: configuration, front, queue, back.
//
//  channel   ports                     carries
//  input     s_tvalid/s_tready         load key, load row element, lookup requests
//  result    m_tvalid/m_tready         one gathered row element per transfer
//  config    cfg_wr_en/addr/wdata      key_count, row_length, fill_value writes
//
// A load is written as the back end pops it. A lookup latches its key, then scans
// up to min(key_count, ENTRIES) keys (one key memory read per cycle, stopping at
// the highest match), then streams row_length elements, clamped to 1..ROW_MAX,
// from the single row memory read port. The queue lets the input keep taking
// requests while the back end works or the result side stalls. Reset is
// synchronous and clears control state only; the stores need no clearing.
module key_match_row_gather #(
    parameter int ENTRIES      = kmrg_pkg::ENTRIES_DEF,
    parameter int ROW_MAX      = kmrg_pkg::ROW_MAX_DEF,
    parameter int ELEMENT_BITS = kmrg_pkg::ELEMENT_BITS_DEF,
    parameter int QUEUE_DEPTH  = kmrg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] search_key, [37:32] entry_position, [43:38] element_position,
    // [75:44] element_data, [79:76] zero
    input  logic [kmrg_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] operation
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [5:0] matched_entry, [37:6] row_element, [39:38] zero
    output logic [kmrg_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] hit
    output logic                            m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [kmrg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [kmrg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import kmrg_pkg::*;

    logic [LEN_W-1:0]  key_count_reg;
    logic [LEN_W-1:0]  row_length_reg;
    logic [FILL_W-1:0] fill_value_reg;

    logic              q_push, q_full, q_pop, q_valid;
    kmrg_cmd_t         q_in_cmd, q_out_cmd;
    logic [POS_W-1:0]  out_entry;
    logic [DATA_W-1:0] out_element;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg  <= '0;
            row_length_reg <= LEN_W'(1);
            fill_value_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_KEY_COUNT:  key_count_reg  <= cfg_wdata[LEN_W-1:0];
                CFG_ROW_LENGTH: row_length_reg <= cfg_wdata[LEN_W-1:0];
                CFG_FILL_VALUE: fill_value_reg <= cfg_wdata[FILL_W-1:0];
                default: ;
            endcase
        end
    end

    kmrg_front #(
        .ENTRIES (ENTRIES),
        .ROW_MAX (ROW_MAX)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in_cmd)
    );

    kmrg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_in_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_out_cmd),
        .valid   (q_valid)
    );

    kmrg_back #(
        .ENTRIES      (ENTRIES),
        .ROW_MAX      (ROW_MAX),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_cmd       (q_out_cmd),
        .q_pop       (q_pop),
        .key_count   (key_count_reg),
        .row_length  (row_length_reg),
        .fill_value  (fill_value_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_hit     (m_tuser),
        .out_entry   (out_entry),
        .out_element (out_element),
        .out_last    (m_tlast)
    );

    // Pack the result fields
    assign m_tdata = {2'b00, out_element, out_entry};

endmodule

FILE: tb/sv/tb_key_match_row_gather.sv
// Self-checking testbench for key_match_row_gather: directed table, random phases, scoreboard.
module tb_key_match_row_gather;
    timeunit 1ns;
    timeprecision 1ps;

    import kmrg_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int N_ENTRIES      = 64;
    localparam int N_ROW          = 64;
    // worst back end pass: start, full key scan, longest row, plus queued loads
    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_PRINTED    = 20;
    localparam int N_PHASES       = 7;

    // one gathered element as seen on the result channel
    typedef struct {
        logic        hit;
        logic [5:0]  entry;
        logic [31:0] value;
        logic        last;
    } gather_t;

    // one row of the directed table: a register write or a request
    typedef struct {
        bit                    is_cfg;
        logic [CFG_ADDR_W-1:0] cfg_idx;
        logic [7:0]            cfg_val;
        op_t                   op;
        logic [31:0]           key;
        logic [5:0]            entry;
        logic [5:0]            elem;
        logic [31:0]           data;
        bit                    typed;
        logic [31:0]           miss_value;
        int                    miss_count;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = 2'd0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // mirror of the block state
    logic [31:0] key_mem [N_ENTRIES];
    logic [31:0] row_mem [N_ENTRIES*N_ROW];
    bit          key_written [N_ENTRIES];
    bit          row_written [N_ENTRIES*N_ROW];
    logic [6:0]  key_count_q  = 7'd0;
    logic [6:0]  row_length_q = 7'd1;
    logic [7:0]  fill_q       = 8'd0;

    gather_t  gather_q[$];
    dir_row_t dir_table[$];

    bit steady_flow = 1'b0;
    int n_fail      = 0;
    int n_requests  = 0;
    int n_lookups   = 0;
    int n_hits      = 0;
    int n_results   = 0;
    int n_cfg       = 0;
    int stall_cycles = 0;

    key_match_row_gather dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Count and print one mismatch; keep printing bounded.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_fail++;
        if (n_fail <= MAX_PRINTED)
            $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
    endtask

    // Keys that collide often, extremes among them.
    function automatic logic [31:0] pool_key();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            default: return 32'h0000_0005;
        endcase
    endfunction

    // Saturate key_count to the table size.
    function automatic int eff_count();
        return (key_count_q > N_ENTRIES) ? N_ENTRIES : int'(key_count_q);
    endfunction

    // Clamp row_length into 1..ROW_MAX.
    function automatic int eff_length();
        int len;
        len = int'(row_length_q);
        if (len == 0)
            len = 1;
        if (len > N_ROW)
            len = N_ROW;
        return len;
    endfunction

    // Highest matching position among the active keys.
    function automatic bit find_match(input logic [31:0] k, output int pos);
        bit found;
        found = 1'b0;
        pos   = 0;
        for (int i = 0; i < eff_count(); i++) begin
            if (key_mem[i] == k) begin
                found = 1'b1;
                pos   = i;
            end
        end
        return found;
    endfunction

    // Queue the elements one lookup gathers.
    function automatic void predict_gather(input logic [31:0] k);
        gather_t g;
        int      pos;
        int      len;
        bit      found;
        found = find_match(k, pos);
        len   = eff_length();
        if (found)
            n_hits++;
        for (int i = 0; i < len; i++) begin
            g.hit   = found;
            g.entry = found ? 6'(pos) : 6'd0;
            g.value = found ? row_mem[pos*N_ROW + i] : {24'd0, fill_q};
            g.last  = (i == len - 1);
            gather_q.push_back(g);
        end
    endfunction

    // Apply one accepted request to the mirror.
    function automatic void note_request(input op_t op, input logic [31:0] key,
                                         input logic [5:0] entry, input logic [5:0] elem,
                                         input logic [31:0] data, input bit typed,
                                         input logic [31:0] miss_value, input int miss_count);
        gather_t g;
        case (op)
            OP_LOAD_KEY: begin
                key_mem[entry]     = key;
                key_written[entry] = 1'b1;
            end
            OP_LOAD_ROW: begin
                row_mem[{entry, elem}]     = data;
                row_written[{entry, elem}] = 1'b1;
            end
            OP_LOOKUP: begin
                n_lookups++;
                if (typed) begin
                    for (int i = 0; i < miss_count; i++) begin
                        g.hit   = 1'b0;
                        g.entry = 6'd0;
                        g.value = miss_value;
                        g.last  = (i == miss_count - 1);
                        gather_q.push_back(g);
                    end
                end else begin
                    predict_gather(key);
                end
            end
            default: ;
        endcase
    endfunction

    // Drive one request, idle at random first, and wait for the handshake.
    task automatic push_request(input op_t op, input logic [31:0] key, input logic [5:0] entry,
                                input logic [5:0] elem, input logic [31:0] data,
                                input bit typed = 1'b0, input logic [31:0] miss_value = '0,
                                input int miss_count = 0);
        if (!steady_flow && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, data, elem, entry, key};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        n_requests++;
        note_request(op, key, entry, elem, data, typed, miss_value, miss_count);
    endtask

    // Drop valid and hold until every expected element has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (gather_q.size() != 0)
            @(posedge aclk);
    endtask

    // Drain, then let trailing loads retire before touching registers.
    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register and mirror it.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_KEY_COUNT:  key_count_q  = val[6:0];
            CFG_ROW_LENGTH: row_length_q = val[6:0];
            CFG_FILL_VALUE: fill_q       = val;
            default: ;
        endcase
        n_cfg++;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Lookup with the loads it needs first: active keys and the hit row written.
    task automatic issue_lookup();
        int          cnt;
        int          pos;
        int          len;
        int          r;
        bit          found;
        logic [31:0] k;
        cnt = eff_count();
        for (int i = 0; i < cnt; i++) begin
            if (!key_written[i])
                push_request(OP_LOAD_KEY, pool_key(), 6'(i), 6'($urandom), $urandom);
        end
        r = $urandom_range(99);
        if (cnt > 0 && r < 60)
            k = key_mem[$urandom_range(0, cnt - 1)];
        else if (r < 80)
            k = pool_key();
        else
            k = $urandom;
        found = find_match(k, pos);
        len   = eff_length();
        if (found) begin
            for (int e = 0; e < len; e++) begin
                if (!row_written[pos*N_ROW + e])
                    push_request(OP_LOAD_ROW, $urandom, 6'(pos), 6'(e), $urandom);
            end
        end
        push_request(OP_LOOKUP, k, 6'($urandom), 6'($urandom), $urandom);
    endtask

    // One random request, mostly lookups and loads into the active region.
    task automatic random_item();
        int          r;
        int          cnt;
        int          ent;
        int          el;
        logic [31:0] k;
        r   = $urandom_range(99);
        cnt = eff_count();
        if (cnt > 0 && $urandom_range(1) == 1)
            ent = $urandom_range(0, cnt - 1);
        else
            ent = $urandom_range(0, N_ENTRIES - 1);
        if (r < 45) begin
            issue_lookup();
        end else if (r < 65) begin
            k = ($urandom_range(99) < 60) ? pool_key() : $urandom;
            push_request(OP_LOAD_KEY, k, 6'(ent), 6'($urandom), $urandom);
        end else if (r < 90) begin
            if ($urandom_range(99) < 70)
                el = $urandom_range(0, eff_length() - 1);
            else
                el = $urandom_range(0, N_ROW - 1);
            push_request(OP_LOAD_ROW, $urandom, 6'(ent), 6'(el), $urandom);
        end else begin
            push_request(OP_NONE, $urandom, 6'($urandom), 6'($urandom), $urandom);
        end
    endtask

    function automatic void add_cfg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
        dir_row_t d;
        d.is_cfg     = 1'b1;
        d.cfg_idx    = idx;
        d.cfg_val    = val;
        d.op         = OP_NONE;
        d.key        = '0;
        d.entry      = '0;
        d.elem       = '0;
        d.data       = '0;
        d.typed      = 1'b0;
        d.miss_value = '0;
        d.miss_count = 0;
        dir_table.push_back(d);
    endfunction

    function automatic void add_req(input op_t op, input logic [31:0] key,
                                    input logic [5:0] entry, input logic [5:0] elem,
                                    input logic [31:0] data, input bit typed = 1'b0,
                                    input logic [31:0] miss_value = '0,
                                    input int miss_count = 0);
        dir_row_t d;
        d.is_cfg     = 1'b0;
        d.cfg_idx    = '0;
        d.cfg_val    = '0;
        d.op         = op;
        d.key        = key;
        d.entry      = entry;
        d.elem       = elem;
        d.data       = data;
        d.typed      = typed;
        d.miss_value = miss_value;
        d.miss_count = miss_count;
        dir_table.push_back(d);
    endfunction

    // Stall the result side at random, except in the steady stretch.
    always @(posedge aclk) begin
        m_tready <= steady_flow || ($urandom_range(99) >= 34);
    end

    // Check each accepted element against the oldest expectation.
    always @(posedge aclk) begin
        gather_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (gather_q.size() == 0) begin
                report_mismatch("element with nothing pending", m_tdata[37:6], '0);
            end else begin
                want = gather_q.pop_front();
                if (m_tuser !== want.hit)
                    report_mismatch("hit", 32'(m_tuser), 32'(want.hit));
                if (m_tdata[5:0] !== want.entry)
                    report_mismatch("matched_entry", 32'(m_tdata[5:0]), 32'(want.entry));
                if (m_tdata[37:6] !== want.value)
                    report_mismatch("row_element", m_tdata[37:6], want.value);
                if (m_tlast !== want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // End the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [7:0] ph_kc [N_PHASES];
        logic [7:0] ph_rl [N_PHASES];
        logic [7:0] ph_fv [N_PHASES];
        int         ph_items [N_PHASES];

        // After reset: zero key count, one element, fill zero; op 3 is dropped.
        add_req(OP_LOOKUP, 32'h0000_0000, 6'd0, 6'd0, 32'd0, 1'b1, 32'd0, 1);
        add_req(OP_NONE, 32'hFFFF_FFFF, 6'h3F, 6'h3F, 32'hFFFF_FFFF);
        // Extreme keys, a duplicate at a higher position, rows for the hits.
        add_req(OP_LOAD_KEY, 32'h8000_0000, 6'd0, 6'd0, 32'd0);
        add_req(OP_LOAD_KEY, 32'h7FFF_FFFF, 6'd1, 6'd0, 32'd0);
        add_req(OP_LOAD_KEY, 32'h8000_0000, 6'd2, 6'd0, 32'd0);
        add_req(OP_LOAD_ROW, 32'd0, 6'd2, 6'd0, 32'hFFFF_FFFF);
        add_req(OP_LOAD_ROW, 32'd0, 6'd2, 6'd1, 32'h0000_0000);
        add_req(OP_LOAD_ROW, 32'd0, 6'd1, 6'd0, 32'hA5A5_5A5A);
        add_req(OP_LOAD_ROW, 32'd0, 6'd1, 6'd1, 32'h5A5A_A5A5);
        add_req(OP_LOAD_ROW, 32'd0, 6'd0, 6'd0, 32'h0000_0001);
        // Key count still zero: stored key misses.
        add_req(OP_LOOKUP, 32'h8000_0000, 6'd0, 6'd0, 32'd0, 1'b1, 32'd0, 1);
        add_cfg(CFG_KEY_COUNT, 8'd3);
        add_cfg(CFG_ROW_LENGTH, 8'd2);
        add_cfg(CFG_FILL_VALUE, 8'hFF);
        add_req(OP_LOOKUP, 32'h8000_0000, 6'd0, 6'd0, 32'd0);
        add_req(OP_LOOKUP, 32'h7FFF_FFFF, 6'd0, 6'd0, 32'd0);
        add_req(OP_LOOKUP, 32'h0000_0000, 6'd0, 6'd0, 32'd0, 1'b1, 32'h0000_00FF, 2);
        // Row length zero acts as one.
        add_cfg(CFG_ROW_LENGTH, 8'd0);
        add_req(OP_LOOKUP, 32'h7FFF_FFFF, 6'd0, 6'd0, 32'd0);
        // Row length above the maximum clamps to a full row.
        add_cfg(CFG_ROW_LENGTH, 8'hFF);
        add_req(OP_LOOKUP, 32'h0000_0001, 6'd0, 6'd0, 32'd0, 1'b1, 32'h0000_00FF, 64);
        add_req(OP_LOAD_ROW, 32'd0, 6'h3F, 6'h3F, 32'hFFFF_FFFF);
        add_req(OP_LOAD_KEY, 32'h0000_0000, 6'h3F, 6'd0, 32'd0);
        // Duplicate drops out of the active range: lower position wins.
        add_cfg(CFG_KEY_COUNT, 8'd2);
        add_cfg(CFG_ROW_LENGTH, 8'd1);
        add_cfg(CFG_FILL_VALUE, 8'd0);
        add_req(OP_LOOKUP, 32'h8000_0000, 6'd0, 6'd0, 32'd0);
        add_req(OP_NONE, 32'd0, 6'd0, 6'd0, 32'd0);

        // Random phase settings, extremes included; loads a lookup needs come on top.
        ph_kc[0] = 8'hFF;                       ph_rl[0] = 8'd4;
        ph_fv[0] = 8'h00;                       ph_items[0] = 6;
        ph_kc[1] = 8'd0;                        ph_rl[1] = 8'd3;
        ph_fv[1] = 8'hFF;                       ph_items[1] = 8;
        ph_kc[2] = 8'd1;                        ph_rl[2] = 8'd64;
        ph_fv[2] = 8'($urandom_range(0, 255));  ph_items[2] = 4;
        ph_kc[3] = 8'($urandom_range(1, 64));   ph_rl[3] = 8'($urandom_range(1, 6));
        ph_fv[3] = 8'($urandom_range(0, 255));  ph_items[3] = 16;
        ph_kc[4] = 8'd64;                       ph_rl[4] = 8'd0;
        ph_fv[4] = 8'($urandom_range(0, 255));  ph_items[4] = 4;
        ph_kc[5] = 8'($urandom_range(0, 255));  ph_rl[5] = 8'($urandom_range(1, 8));
        ph_fv[5] = 8'($urandom_range(0, 255));  ph_items[5] = 4;
        ph_kc[6] = 8'($urandom_range(1, 64));   ph_rl[6] = 8'd2;
        ph_fv[6] = 8'($urandom_range(0, 255));  ph_items[6] = 4;

        // Hold reset low, then release it.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table.
        foreach (dir_table[i]) begin
            if (dir_table[i].is_cfg) begin
                wait_idle();
                write_reg(dir_table[i].cfg_idx, dir_table[i].cfg_val);
            end else begin
                push_request(dir_table[i].op, dir_table[i].key, dir_table[i].entry,
                             dir_table[i].elem, dir_table[i].data, dir_table[i].typed,
                             dir_table[i].miss_value, dir_table[i].miss_count);
            end
        end

        // Random phases; phase 3 runs without idling on either side.
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            write_reg(CFG_KEY_COUNT, ph_kc[p]);
            write_reg(CFG_ROW_LENGTH, ph_rl[p]);
            write_reg(CFG_FILL_VALUE, ph_fv[p]);
            steady_flow = (p == 3);
            for (int j = 0; j < ph_items[p]; j++) begin
                random_item();
                // pause the sender mid-phase until the result side catches up
                if (p == 1 && j == 3)
                    drain_results();
            end
        end
        steady_flow = 1'b0;

        // Drop valid, drain, then let the block settle.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d requests, %0d lookups (%0d hits), %0d elements checked",
                 n_requests, n_lookups, n_hits, n_results);
        $display("%0d register writes over the directed table and %0d random phases",
                 n_cfg, N_PHASES);
        if (n_fail == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
